FILE: rtl/assert_macros.svh
// assertion macros shared by the sorter rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define QSL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sorter check failed: same-cycle implication");

// next-cycle implication, checked outside reset
`define QSL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sorter check failed: next-cycle implication");

`endif

FILE: rtl/qsl_pkg.sv
// types and constants shared by the quicksort sorter modules
package qsl_pkg;

  localparam int DATA_W = 32;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_POP,
    ST_RANGE,
    ST_PIVOT,
    ST_SCAN,
    ST_CMP,
    ST_SWAP1,
    ST_SWAP2,
    ST_FIN1,
    ST_FIN2,
    ST_PUSH2,
    ST_EMIT
  } sort_state_t;

  // range stack controls from the sequencer
  typedef struct packed {
    logic push;
    logic pop;
  } stack_ctl_t;

endpackage

FILE: rtl/qsl_range_stack.sv
// range stack: holds pending {low, high} index pairs of the quicksort
`include "assert_macros.svh"

module qsl_range_stack #(
  parameter int AW    = 6,
  parameter int DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  qsl_pkg::stack_ctl_t ctl,
  input  logic [2*AW-1:0]     push_data,
  output logic [2*AW-1:0]     top_data,
  output logic                empty
);

  localparam int IW  = $clog2(DEPTH);
  localparam int SPW = $clog2(DEPTH + 1);
  localparam logic [SPW-1:0] DEPTH_C = SPW'(DEPTH);

  logic [2*AW-1:0] stack_mem [DEPTH];
  logic [SPW-1:0]  sp_r;
  logic [SPW-1:0]  sp_nxt;
  logic [SPW-1:0]  sp_dec;
  logic [2*AW-1:0] top_data_r;
  logic            push_ok;

  assign sp_dec  = sp_r - SPW'(1);
  assign push_ok = ctl.push && (sp_r < DEPTH_C);
  assign empty   = (sp_r == '0);
  assign top_data = top_data_r;

  // stack pointer update
  always_comb begin
    sp_nxt = sp_r;
    if (push_ok) begin
      sp_nxt = sp_r + SPW'(1);
    end else if (ctl.pop) begin
      sp_nxt = sp_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r <= '0;
    end else begin
      sp_r <= sp_nxt;
    end
  end

  // storage, registered read on pop
  always_ff @(posedge clk) begin
    if (push_ok) begin
      stack_mem[sp_r[IW-1:0]] <= push_data;
    end
    if (ctl.pop) begin
      top_data_r <= stack_mem[sp_dec[IW-1:0]];
    end
  end

  `QSL_ASSERT_IMP(a_no_pop_when_empty, clk, rst_n, ctl.pop, sp_r != '0)
  `QSL_ASSERT_IMP(a_no_push_and_pop, clk, rst_n, ctl.push, !ctl.pop)

endmodule

FILE: rtl/quicksort_lomuto_sorter_unit.sv
// top level of the quicksort sorter: load, in-place lomuto sort, ordered read-out
//
// Values are loaded one beat per cycle while busy is low. A beat with in_last set, or the
// beat that fills the SIZE-entry store, starts the sort and busy goes high. The sort is one
// shared compare on a two-port element memory (one write, one registered read a cycle)
// under a small sequencer: each range passes through pop, pivot fetch, the scan, the
// pivot placement and the pushes; each scanned element through scan and compare, and a
// swap adds writes to both slots. A sorted run of n values is then driven out on
// consecutive cycles, out_valid high on each beat and out_last_res on the final one; the
// receiver cannot stall and must take every beat. No clearing pass after reset.
`include "assert_macros.svh"

module quicksort_lomuto_sorter_unit #(
  parameter int SIZE = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_value,
  input  logic               in_last,
  output logic               out_valid,
  output logic signed [31:0] out_sorted_value,
  output logic               out_last_res
);

  localparam int AW = $clog2(SIZE);
  localparam int CW = $clog2(SIZE + 1);
  localparam logic [CW-1:0] FILL_C = CW'(SIZE - 1);

  qsl_pkg::sort_state_t state_r, state_nxt;

  // element store
  logic [qsl_pkg::DATA_W-1:0] elem_mem [SIZE];
  logic [qsl_pkg::DATA_W-1:0] rd_data_r;
  logic                       rd_en;
  logic [AW-1:0]              rd_addr;
  logic                       wr_en;
  logic [AW-1:0]              wr_addr;
  logic [qsl_pkg::DATA_W-1:0] wr_data;

  // sequencer datapath
  logic [CW-1:0]              count_r, count_nxt;
  logic [AW-1:0]              lo_r, lo_nxt;
  logic [AW-1:0]              hi_r, hi_nxt;
  logic [AW-1:0]              place_r, place_nxt;
  logic [AW-1:0]              scan_r, scan_nxt;
  logic [AW-1:0]              k_r, k_nxt;
  logic [qsl_pkg::DATA_W-1:0] pivot_r, pivot_nxt;
  logic [qsl_pkg::DATA_W-1:0] hold_r, hold_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic                       out_last_r, out_last_nxt;

  // range stack link
  qsl_pkg::stack_ctl_t        stk_ctl;
  logic [2*AW-1:0]            stk_push_data;
  logic [2*AW-1:0]            stk_top;
  logic                       stk_empty;
  logic [AW-1:0]              top_lo;
  logic [AW-1:0]              top_hi;

  logic                       accept;
  logic                       load_done;
  logic                       not_above;
  logic [CW-1:0]              n_minus1;
  logic                       push_left;
  logic                       push_right;

  assign accept    = start && !busy;
  assign load_done = in_last || (count_r == FILL_C);
  assign top_lo    = stk_top[2*AW-1:AW];
  assign top_hi    = stk_top[AW-1:0];
  assign not_above = $signed(rd_data_r) <= $signed(pivot_r);
  assign n_minus1  = count_r - CW'(1);
  assign push_left  = {1'b0, place_r} >= ({1'b0, lo_r} + (AW+1)'(2));
  assign push_right = ({1'b0, place_r} + (AW+1)'(2)) <= {1'b0, hi_r};

  assign busy             = (state_r != qsl_pkg::ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_last_res     = out_last_r;
  assign out_sorted_value = $signed(rd_data_r);

  qsl_range_stack #(
    .AW    (AW),
    .DEPTH (SIZE)
  ) u_stack (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (stk_ctl),
    .push_data (stk_push_data),
    .top_data  (stk_top),
    .empty     (stk_empty)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      qsl_pkg::ST_IDLE: begin
        if (accept && load_done) begin
          state_nxt = qsl_pkg::ST_START;
        end
      end
      qsl_pkg::ST_START: begin
        state_nxt = (count_r >= CW'(2)) ? qsl_pkg::ST_POP : qsl_pkg::ST_EMIT;
      end
      qsl_pkg::ST_POP: begin
        state_nxt = stk_empty ? qsl_pkg::ST_EMIT : qsl_pkg::ST_RANGE;
      end
      qsl_pkg::ST_RANGE: begin
        state_nxt = (top_lo >= top_hi) ? qsl_pkg::ST_POP : qsl_pkg::ST_PIVOT;
      end
      qsl_pkg::ST_PIVOT: state_nxt = qsl_pkg::ST_SCAN;
      qsl_pkg::ST_SCAN: begin
        state_nxt = (scan_r < hi_r) ? qsl_pkg::ST_CMP : qsl_pkg::ST_FIN1;
      end
      qsl_pkg::ST_CMP: begin
        if (not_above && (place_r != scan_r)) begin
          state_nxt = qsl_pkg::ST_SWAP1;
        end else begin
          state_nxt = qsl_pkg::ST_SCAN;
        end
      end
      qsl_pkg::ST_SWAP1: state_nxt = qsl_pkg::ST_SWAP2;
      qsl_pkg::ST_SWAP2: state_nxt = qsl_pkg::ST_SCAN;
      qsl_pkg::ST_FIN1:  state_nxt = qsl_pkg::ST_FIN2;
      qsl_pkg::ST_FIN2:  state_nxt = qsl_pkg::ST_PUSH2;
      qsl_pkg::ST_PUSH2: state_nxt = qsl_pkg::ST_POP;
      qsl_pkg::ST_EMIT: begin
        if ({1'b0, k_r} == n_minus1) begin
          state_nxt = qsl_pkg::ST_IDLE;
        end
      end
      default: state_nxt = qsl_pkg::ST_IDLE;
    endcase
  end

  // memory, stack and datapath controls
  always_comb begin
    rd_en         = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = '0;
    stk_ctl       = '0;
    stk_push_data = '0;
    count_nxt     = count_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    place_nxt     = place_r;
    scan_nxt      = scan_r;
    k_nxt         = k_r;
    pivot_nxt     = pivot_r;
    hold_nxt      = hold_r;
    out_valid_nxt = 1'b0;
    out_last_nxt  = 1'b0;
    case (state_r)
      qsl_pkg::ST_IDLE: begin
        // load one beat into the next free entry
        if (accept) begin
          wr_en     = 1'b1;
          wr_addr   = count_r[AW-1:0];
          wr_data   = in_value;
          count_nxt = count_r + CW'(1);
        end
      end
      qsl_pkg::ST_START: begin
        // all loaded values form the first range
        if (count_r >= CW'(2)) begin
          stk_ctl.push  = 1'b1;
          stk_push_data = {AW'(0), n_minus1[AW-1:0]};
        end
        k_nxt = '0;
      end
      qsl_pkg::ST_POP: begin
        if (!stk_empty) begin
          stk_ctl.pop = 1'b1;
        end
        k_nxt = '0;
      end
      qsl_pkg::ST_RANGE: begin
        // fetch the pivot at the high end
        lo_nxt = top_lo;
        hi_nxt = top_hi;
        if (top_lo < top_hi) begin
          rd_en   = 1'b1;
          rd_addr = top_hi;
        end
      end
      qsl_pkg::ST_PIVOT: begin
        pivot_nxt = rd_data_r;
        place_nxt = lo_r;
        scan_nxt  = lo_r;
      end
      qsl_pkg::ST_SCAN: begin
        rd_en   = 1'b1;
        rd_addr = (scan_r < hi_r) ? scan_r : place_r;
      end
      qsl_pkg::ST_CMP: begin
        if (not_above) begin
          if (place_r == scan_r) begin
            place_nxt = place_r + AW'(1);
            scan_nxt  = scan_r + AW'(1);
          end else begin
            hold_nxt = rd_data_r;
            rd_en    = 1'b1;
            rd_addr  = place_r;
          end
        end else begin
          scan_nxt = scan_r + AW'(1);
        end
      end
      qsl_pkg::ST_SWAP1: begin
        // scanned value into the place slot, keep the displaced one
        wr_en    = 1'b1;
        wr_addr  = place_r;
        wr_data  = hold_r;
        hold_nxt = rd_data_r;
      end
      qsl_pkg::ST_SWAP2: begin
        wr_en     = 1'b1;
        wr_addr   = scan_r;
        wr_data   = hold_r;
        place_nxt = place_r + AW'(1);
        scan_nxt  = scan_r + AW'(1);
      end
      qsl_pkg::ST_FIN1: begin
        // pivot into its final slot
        wr_en    = 1'b1;
        wr_addr  = place_r;
        wr_data  = pivot_r;
        hold_nxt = rd_data_r;
      end
      qsl_pkg::ST_FIN2: begin
        wr_en   = 1'b1;
        wr_addr = hi_r;
        wr_data = hold_r;
        if (push_left) begin
          stk_ctl.push  = 1'b1;
          stk_push_data = {lo_r, place_r - AW'(1)};
        end
      end
      qsl_pkg::ST_PUSH2: begin
        if (push_right) begin
          stk_ctl.push  = 1'b1;
          stk_push_data = {place_r + AW'(1), hi_r};
        end
      end
      qsl_pkg::ST_EMIT: begin
        // one read a cycle, strobe follows the registered data
        rd_en         = 1'b1;
        rd_addr       = k_r;
        out_valid_nxt = 1'b1;
        out_last_nxt  = ({1'b0, k_r} == n_minus1);
        k_nxt         = k_r + AW'(1);
        if ({1'b0, k_r} == n_minus1) begin
          count_nxt = '0;
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= qsl_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    place_r <= place_nxt;
    scan_r  <= scan_nxt;
    k_r     <= k_nxt;
    pivot_r <= pivot_nxt;
    hold_r  <= hold_nxt;
  end

  // element store, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      elem_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= elem_mem[rd_addr];
    end
  end

  `QSL_ASSERT_NXT(a_emit_strobes, clk, rst_n, state_r == qsl_pkg::ST_EMIT, out_valid_r)
  `QSL_ASSERT_IMP(a_final_beat_idle, clk, rst_n, out_valid_r && out_last_r, !busy)
  `QSL_ASSERT_IMP(a_place_behind_scan, clk, rst_n, state_r == qsl_pkg::ST_SCAN, place_r <= scan_r)
  `QSL_ASSERT_IMP(a_count_in_range, clk, rst_n, 1'b1, count_r <= CW'(SIZE))

endmodule
